// File: sv/wjs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wjs_pkg
// Shared types and constants of the weighted job schedule block.
// ----------------------------------------------------------------------------
package wjs_pkg;

  localparam int DAY_W  = 11;  // day count, duration and day counter
  localparam int OUT_W  = 26;  // best total on the result channel
  localparam int DATA_W = 32;  // configuration data bus
  localparam int ADDR_W = 3;   // configuration byte address

  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  // register indexes on the configuration port
  localparam logic REG_NUM_DAYS = 1'b0;

  // control broadcast from the day sequencer to every cell of the row
  typedef struct packed {
    logic             wr_en;   // fold the candidate into the matching cell
    logic [DAY_W-1:0] wr_idx;  // cell offset from the current day
    logic             shift;   // advance the window by one day
    logic             clear;   // end of schedule: wipe all cells
  } wjs_ctl_t;

endpackage

// File: sv/wjs_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wjs_cell
// One cell of the pending-profit row: holds the best profit pushed forward to
// the day IDX days ahead of the current day, and on each shift takes its upper
// neighbor's value with this day's candidate folded in.
// ----------------------------------------------------------------------------
module wjs_cell #(
  parameter int VAL_W = 27,
  parameter int IDX   = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  wjs_pkg::wjs_ctl_t   ctl,
  input  logic [VAL_W-1:0]    cand,
  input  logic [VAL_W-1:0]    nbr_val,
  output logic [VAL_W-1:0]    val_out
);
  import wjs_pkg::*;

  logic [VAL_W-1:0] val_r;
  logic [VAL_W-1:0] val_nxt;
  logic [VAL_W-1:0] shifted;
  logic             hit;

  // the neighbor's entry is the one this day's candidate targets
  assign hit = ctl.wr_en && (32'(ctl.wr_idx) == 32'(IDX + 1));

  // neighbor value after this day's candidate is folded in
  assign shifted = (hit && (cand > nbr_val)) ? cand : nbr_val;

  always_comb begin
    priority if (ctl.clear) begin
      val_nxt = '0;
    end else if (ctl.shift) begin
      val_nxt = shifted;
    end else begin
      val_nxt = val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else begin
      val_r <= val_nxt;
    end
  end

  assign val_out = val_r;

endmodule

// File: sv/wjs_row.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wjs_row
// Row of pending-profit cells; cell k holds the entry k days past the
// current day's entry. The row shifts down by one cell per finished day.
// ----------------------------------------------------------------------------
module wjs_row #(
  parameter int VAL_W  = 27,
  parameter int NCELLS = 1025
) (
  input  logic                clk,
  input  logic                rst_n,
  input  wjs_pkg::wjs_ctl_t   ctl,
  input  logic [VAL_W-1:0]    cand,
  output logic [VAL_W-1:0]    head0,
  output logic [VAL_W-1:0]    head1
);
  import wjs_pkg::*;

  logic [VAL_W-1:0] val_w [NCELLS+1];

  // nothing beyond the last cell was ever written
  assign val_w[NCELLS] = '0;

  for (genvar k = 0; k < NCELLS; k++) begin : g_cell
    wjs_cell #(
      .VAL_W (VAL_W),
      .IDX   (k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .cand    (cand),
      .nbr_val (val_w[k+1]),
      .val_out (val_w[k])
    );
  end

  assign head0 = val_w[0];
  assign head1 = val_w[1];

endmodule

// File: sv/weighted_job_schedule_max_profit_top.sv
`timescale 1ns / 1ps
// The best total appears on out_valid in the cycle after the last day's item is accepted.
// Throughput: one item per cycle while in_stall is low; the day loop is one read, fold
// and shift of the cell row.
// The input stalls only when the last day's item arrives while a result is still held under out_stall.
// Reset (synchronous, active low) clears every cell, sets the day
// counter to one and num_days to one; there is no clearing pass.
// ----------------------------------------------------------------------------
// weighted_job_schedule_max_profit_top
// Forward dynamic program for weighted job scheduling over a row of cells.
// ----------------------------------------------------------------------------
module weighted_job_schedule_max_profit_top #(
  parameter int MAX_DAYS    = 1024,
  parameter int PROFIT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [wjs_pkg::ADDR_W-1:0]      paddr,
  input  logic [wjs_pkg::DATA_W-1:0]      pwdata,
  output logic [wjs_pkg::DATA_W-1:0]      prdata,
  output logic                            pready,
  // job items
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [wjs_pkg::DAY_W-1:0]       in_job_duration,
  input  logic [PROFIT_BITS-1:0]          in_job_profit,
  // result items
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [wjs_pkg::OUT_W-1:0]       out_best_total
);
  import wjs_pkg::*;

  localparam int VAL_W  = PROFIT_BITS + $clog2(MAX_DAYS + 1);
  localparam int NCELLS = MAX_DAYS + 1;
  localparam int EXT_W  = VAL_W + OUT_W;

  logic [DAY_W-1:0] num_days_r;
  logic [DAY_W-1:0] num_days_nxt;
  logic [DAY_W-1:0] day_r;
  logic [DAY_W-1:0] day_nxt;
  logic [VAL_W-1:0] carried_r;
  logic [VAL_W-1:0] carried_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [OUT_W-1:0] out_best_r;
  logic [OUT_W-1:0] out_best_nxt;

  logic             cfg_wr;
  logic [DAY_W-1:0] n_eff;
  logic [DAY_W-1:0] dur;
  logic             in_range;
  logic             is_last;
  logic             fits;
  logic             accept;
  logic [VAL_W-1:0] head0;
  logic [VAL_W-1:0] head1;
  logic [VAL_W-1:0] cur;
  logic [VAL_W-1:0] cand;
  logic [VAL_W-1:0] end_entry;
  logic [VAL_W-1:0] best;
  logic [EXT_W-1:0] best_x;
  wjs_ctl_t         ctl;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_NUM_DAYS);

  always_comb begin
    num_days_nxt = num_days_r;
    if (cfg_wr) begin
      num_days_nxt = pwdata[DAY_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_NUM_DAYS) ? DATA_W'(num_days_r) : '0;

  // ---------------- day sequencer ----------------
  always_comb begin
    if (num_days_r == '0) begin
      n_eff = DAY_W'(1);
    end else if (32'(num_days_r) > 32'(MAX_DAYS)) begin
      n_eff = DAY_W'(MAX_DAYS);
    end else begin
      n_eff = num_days_r;
    end
  end

  assign dur      = (in_job_duration == '0) ? DAY_W'(1) : in_job_duration;
  assign in_range = (day_r <= n_eff);
  assign is_last  = (day_r >= n_eff);
  // job ends by the day after the last day
  assign fits     = ({1'b0, day_r} + {1'b0, dur}) <= ({1'b0, n_eff} + (DAY_W+1)'(1));

  assign in_stall = out_valid_r && out_stall && is_last;
  assign accept   = in_valid && !in_stall;

  // past the end, every entry at or behind the clamped day is already in carried_r
  assign cur  = (in_range && (head0 > carried_r)) ? head0 : carried_r;
  assign cand = cur + VAL_W'(in_job_profit);

  always_comb begin
    end_entry = '0;
    if (in_range) begin
      // entry of the day after the last, including today's job if it ends there
      end_entry = head1;
      if (fits && (dur == DAY_W'(1)) && (cand > head1)) begin
        end_entry = cand;
      end
    end else begin
      if (day_r == n_eff + DAY_W'(1)) begin
        end_entry = head0;
      end
      if ((dur == DAY_W'(1)) && (cand > end_entry)) begin
        end_entry = cand;
      end
    end
  end

  assign best   = (end_entry > cur) ? end_entry : cur;
  assign best_x = EXT_W'(best);

  always_comb begin
    ctl.wr_en  = accept && in_range && fits;
    ctl.wr_idx = dur;
    ctl.shift  = accept && !is_last;
    ctl.clear  = accept && is_last;
  end

  always_comb begin
    day_nxt     = day_r;
    carried_nxt = carried_r;
    if (accept) begin
      if (is_last) begin
        day_nxt     = DAY_W'(1);
        carried_nxt = '0;
      end else begin
        day_nxt     = day_r + DAY_W'(1);
        carried_nxt = cur;
      end
    end
  end

  // ---------------- result register ----------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_best_nxt  = out_best_r;
    if (accept && is_last) begin
      out_valid_nxt = 1'b1;
      out_best_nxt  = (best_x > EXT_W'(OUT_MAX)) ? OUT_MAX : best_x[OUT_W-1:0];
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_days_r  <= DAY_W'(1);
      day_r       <= DAY_W'(1);
      carried_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      num_days_r  <= num_days_nxt;
      day_r       <= day_nxt;
      carried_r   <= carried_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_best_r <= out_best_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_best_total = out_best_r;

  // ---------------- cell row ----------------
  wjs_row #(
    .VAL_W  (VAL_W),
    .NCELLS (NCELLS)
  ) u_row (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .cand  (cand),
    .head0 (head0),
    .head1 (head1)
  );

endmodule
